// ----- rtl/pgb_pkg.sv -----
package pgb_pkg;

  // build defaults
  localparam int unsigned NumScreens   = 4;
  localparam int unsigned NumParticles = 32;

  // field widths
  localparam int unsigned KindW   = 2;
  localparam int unsigned AccelW  = 16;
  localparam int unsigned ScreenW = 2;
  localparam int unsigned SlotW   = 5;
  localparam int unsigned PixW    = 11;
  localparam int unsigned KickW   = 10;
  localparam int unsigned QBits   = 4;
  localparam int unsigned PosW    = PixW + QBits;
  localparam int unsigned VelW    = 9;
  localparam int unsigned GravW   = 4;
  localparam int unsigned ThreshW = 18;
  localparam int unsigned SpeedW  = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 18;

  // arithmetic constants
  localparam int unsigned DotPx     = 5;
  localparam int unsigned GravShift = 13;
  localparam int unsigned DragShift = 4;   // damping is v*15/16

  // per-screen gravity tables, bit n for screen n
  localparam logic [3:0] HorizFromY = 4'b1010;
  localparam logic [3:0] HorizNeg   = 4'b0011;

  // register reset values
  localparam logic [PixW-1:0]    WidthRst  = 11'd128;
  localparam logic [PixW-1:0]    HeightRst = 11'd160;
  localparam logic [ThreshW-1:0] ThreshRst = 18'd2000;
  localparam logic [SpeedW-1:0]  SpeedRst  = 8'd128;

  typedef enum logic [KindW-1:0] {
    KindSample = 2'd0,
    KindPlace  = 2'd1,
    KindStep   = 2'd2
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgWidth     = 2'd0,
    CfgHeight    = 2'd1,
    CfgThreshold = 2'd2,
    CfgMaxSpeed  = 2'd3
  } cfg_idx_e;

  // one particle entry in the state memory
  typedef struct packed {
    logic        [PosW-1:0] pos_x;
    logic        [PosW-1:0] pos_y;
    logic signed [VelW-1:0] vel_x;
    logic signed [VelW-1:0] vel_y;
    logic        [PixW-1:0] drw_x;
    logic        [PixW-1:0] drw_y;
  } entry_t;

endpackage

// ----- rtl/pgb_if.sv -----
interface pgb_item_if;
  import pgb_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [KindW-1:0]         kind;
  logic signed [AccelW-1:0] accel_x;
  logic signed [AccelW-1:0] accel_y;
  logic signed [AccelW-1:0] accel_z;
  logic [ScreenW-1:0]       screen;
  logic [SlotW-1:0]         slot;
  logic [PixW-1:0]          place_x;
  logic [PixW-1:0]          place_y;
  logic signed [KickW-1:0]  kick_x;
  logic signed [KickW-1:0]  kick_y;

  modport source (output valid, kind, accel_x, accel_y, accel_z, screen, slot,
                  place_x, place_y, kick_x, kick_y, input ready);
  modport sink   (input valid, kind, accel_x, accel_y, accel_z, screen, slot,
                  place_x, place_y, kick_x, kick_y, output ready);
endinterface

interface pgb_res_if;
  import pgb_pkg::*;
  logic            valid;
  logic            ready;
  logic            shaken;
  logic            moved;
  logic [PixW-1:0] old_x_pixel;
  logic [PixW-1:0] old_y_pixel;
  logic [PixW-1:0] new_x_pixel;
  logic [PixW-1:0] new_y_pixel;

  modport source (output valid, shaken, moved, old_x_pixel, old_y_pixel,
                  new_x_pixel, new_y_pixel, input ready);
  modport sink   (input valid, shaken, moved, old_x_pixel, old_y_pixel,
                  new_x_pixel, new_y_pixel, output ready);
endinterface

interface pgb_cfg_if;
  import pgb_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/pgb_mem.sv -----
module pgb_mem #(
  parameter int unsigned Depth = pgb_pkg::NumScreens * pgb_pkg::NumParticles,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output pgb_pkg::entry_t  rd_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  pgb_pkg::entry_t  wr_data_i
);
  import pgb_pkg::*;

  entry_t mem_q [Depth];
  entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

// ----- rtl/pgb_axis.sv -----
module pgb_axis (
  input  logic                              shaken_i,
  input  logic signed [pgb_pkg::KickW-1:0]  kick_i,
  input  logic signed [pgb_pkg::GravW-1:0]  grav_i,
  input  logic        [pgb_pkg::PosW-1:0]   pos_i,
  input  logic signed [pgb_pkg::VelW-1:0]   vel_i,
  input  logic        [pgb_pkg::PixW-1:0]   bound_i,
  input  logic        [pgb_pkg::SpeedW-1:0] lim_i,
  output logic        [pgb_pkg::PosW-1:0]   pos_o,
  output logic signed [pgb_pkg::VelW-1:0]   vel_o
);
  import pgb_pkg::*;

  logic signed [10:0]     v_sel, v_g, v_drag, lim_s, v_clip;
  logic signed [14:0]     v_mul, v_rnd;
  logic signed [PosW+1:0] p_new, p_max;
  logic signed [VelW:0]   v_neg, v_half;

  always_comb begin
    v_sel  = shaken_i ? 11'(kick_i) : 11'(vel_i);
    v_g    = v_sel + 11'(grav_i);
    // v*15/16 toward zero
    v_mul  = (15'(v_g) <<< DragShift) - 15'(v_g);
    v_rnd  = v_mul + ((v_mul < 0) ? 15'sd15 : 15'sd0);
    v_drag = 11'(v_rnd >>> DragShift);

    lim_s = $signed({3'b000, lim_i});
    if (v_drag > lim_s) begin
      v_clip = lim_s;
    end else if (v_drag < -lim_s) begin
      v_clip = -lim_s;
    end else begin
      v_clip = v_drag;
    end

    p_new  = $signed({2'b00, pos_i}) + (PosW+2)'(v_clip);
    p_max  = $signed({2'b00, bound_i, {QBits{1'b0}}});
    v_neg  = -(VelW+1)'(v_clip);
    v_half = (v_neg + ((v_neg < 0) ? (VelW+1)'(1) : (VelW+1)'(0))) >>> 1;

    if (p_new < 0) begin
      pos_o = '0;
      vel_o = VelW'(v_half);
    end else if (p_new > p_max) begin
      pos_o = PosW'(p_max);
      vel_o = VelW'(v_half);
    end else begin
      pos_o = PosW'(p_new);
      vel_o = VelW'(v_clip);
    end
  end

endmodule

// ----- rtl/particle_gravity_bounce_step.sv -----
// Particle engine step: Q4 fixed-point particles, SCREENS x PARTICLES of them,
// kept in one synchronous state memory (position, velocity, last drawn pixel).
// Each input word is a sample (kind 0: updates the shake flag from the summed
// change of the accelerometer axes), a place (kind 1: particle at rest at a
// clamped pixel) or a step (kind 2: one Euler tick with gravity, 15/16 drag,
// speed clamp and half-speed wall bounce). Every word gives one result word.
// An item is accepted only in StIdle, where its particle entry is read; in
// StExec it is computed, the entry written back and the result register
// loaded, and StExec holds while the result register is still full.
// Configuration words are taken at any time but must only be written while
// the block is idle. The memory has no reset: a step of a never-placed
// particle returns undefined data.
module particle_gravity_bounce_step #(
  parameter int unsigned SCREENS   = pgb_pkg::NumScreens,
  parameter int unsigned PARTICLES = pgb_pkg::NumParticles
) (
  input  logic clk_i,
  input  logic rst_ni,
  pgb_item_if.sink  item_i,
  pgb_res_if.source result_o,
  pgb_cfg_if.sink   cfg_i
);
  import pgb_pkg::*;

  localparam int unsigned Depth = SCREENS * PARTICLES;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StExec = 2'b10
  } state_e;

  typedef struct packed {
    logic            shaken;
    logic            moved;
    logic [PixW-1:0] old_x;
    logic [PixW-1:0] old_y;
    logic [PixW-1:0] new_x;
    logic [PixW-1:0] new_y;
  } res_t;

  function automatic logic [PixW-1:0] bound_px(input logic [PixW-1:0] size);
    return (size > PixW'(DotPx)) ? size - PixW'(DotPx) : '0;
  endfunction

  function automatic logic [AccelW-1:0] abs_diff(input logic signed [AccelW-1:0] a,
                                                 input logic signed [AccelW-1:0] b);
    logic signed [AccelW:0] d;
    d = (AccelW+1)'(a) - (AccelW+1)'(b);
    return AccelW'((d < 0) ? -d : d);
  endfunction

  // ---------------------------------------------------------------- config
  logic [PixW-1:0]    width_q, height_q;
  logic [ThreshW-1:0] thresh_q;
  logic [SpeedW-1:0]  speed_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthRst;
      height_q <= HeightRst;
      thresh_q <= ThreshRst;
      speed_q  <= SpeedRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CfgWidth:     width_q  <= cfg_i.data[PixW-1:0];
        CfgHeight:    height_q <= cfg_i.data[PixW-1:0];
        CfgThreshold: thresh_q <= cfg_i.data[ThreshW-1:0];
        CfgMaxSpeed:  speed_q  <= cfg_i.data[SpeedW-1:0];
      endcase
    end
  end

  // ---------------------------------------------------------------- control
  state_e state_q, state_d;
  logic   in_fire, res_free, commit;

  assign item_i.ready = (state_q == StIdle);
  assign in_fire      = item_i.valid && item_i.ready;
  // result register free now or emptied at this edge
  assign res_free     = !result_o.valid || result_o.ready;
  assign commit       = (state_q == StExec) && res_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_fire) state_d = StExec;
      StExec: if (res_free) state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------- item latch
  logic [AddrW-1:0] addr_full;
  logic             in_range;

  // flat entry index, screen-major
  assign addr_full = AddrW'(item_i.screen) * AddrW'(PARTICLES) + AddrW'(item_i.slot);
  assign in_range  = (32'(item_i.screen) < SCREENS) && (32'(item_i.slot) < PARTICLES);

  logic [KindW-1:0]         kind_q;
  logic signed [AccelW-1:0] ax_q, ay_q, az_q;
  logic [ScreenW-1:0]       scr_q;
  logic [PixW-1:0]          plx_q, ply_q;
  logic signed [KickW-1:0]  kx_q, ky_q;
  logic [AddrW-1:0]         addr_q;
  logic                     range_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q  <= item_i.kind;
      ax_q    <= item_i.accel_x;
      ay_q    <= item_i.accel_y;
      az_q    <= item_i.accel_z;
      scr_q   <= item_i.screen;
      plx_q   <= item_i.place_x;
      ply_q   <= item_i.place_y;
      kx_q    <= item_i.kick_x;
      ky_q    <= item_i.kick_y;
      addr_q  <= addr_full;
      range_q <= in_range;
    end
  end

  // ---------------------------------------------------------------- memory
  entry_t rd_entry, wr_entry;
  logic   wr_en;

  pgb_mem #(
    .Depth (Depth)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (in_fire),
    .rd_addr_i (addr_full),
    .rd_data_o (rd_entry),
    .wr_en_i   (wr_en),
    .wr_addr_i (addr_q),
    .wr_data_i (wr_entry)
  );

  // ---------------------------------------------------------------- shake
  logic signed [AccelW-1:0] lx_q, ly_q, lz_q;
  logic                     shake_q;
  logic [ThreshW-1:0]       delta;
  logic                     is_sample;

  assign delta = ThreshW'(abs_diff(ax_q, lx_q)) + ThreshW'(abs_diff(ay_q, ly_q))
               + ThreshW'(abs_diff(az_q, lz_q));
  assign is_sample = (kind_q == KindSample);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lx_q    <= '0;
      ly_q    <= '0;
      lz_q    <= '0;
      shake_q <= 1'b0;
    end else if (commit && is_sample) begin
      lx_q    <= ax_q;
      ly_q    <= ay_q;
      lz_q    <= az_q;
      shake_q <= (delta > thresh_q);
    end
  end

  // ---------------------------------------------------------------- step
  logic signed [AccelW:0]    horiz;
  logic signed [GravW-1:0]   gx, gy;
  logic [PosW-1:0]           npx, npy;
  logic signed [VelW-1:0]    nvx, nvy;
  logic [PixW-1:0]           bx, by, cx, cy;

  assign bx = bound_px(width_q);
  assign by = bound_px(height_q);

  // horizontal gravity axis and sign depend on the screen's mounting
  always_comb begin
    horiz = HorizFromY[scr_q] ? (AccelW+1)'(ay_q) : (AccelW+1)'(ax_q);
    if (HorizNeg[scr_q]) horiz = -horiz;
    gx = GravW'(horiz >>> GravShift);
    gy = GravW'(az_q >>> GravShift);
  end

  pgb_axis u_axis_x (
    .shaken_i (shake_q),
    .kick_i   (kx_q),
    .grav_i   (gx),
    .pos_i    (rd_entry.pos_x),
    .vel_i    (rd_entry.vel_x),
    .bound_i  (bx),
    .lim_i    (speed_q),
    .pos_o    (npx),
    .vel_o    (nvx)
  );

  pgb_axis u_axis_y (
    .shaken_i (shake_q),
    .kick_i   (ky_q),
    .grav_i   (gy),
    .pos_i    (rd_entry.pos_y),
    .vel_i    (rd_entry.vel_y),
    .bound_i  (by),
    .lim_i    (speed_q),
    .pos_o    (npy),
    .vel_o    (nvy)
  );

  // placement clamp
  assign cx = (plx_q > bx) ? bx : plx_q;
  assign cy = (ply_q > by) ? by : ply_q;

  // ---------------------------------------------------------------- write back / result
  res_t res_d, res_q;
  logic res_vld_q;

  always_comb begin
    wr_en       = 1'b0;
    wr_entry    = rd_entry;
    res_d       = '0;
    res_d.shaken = shake_q;
    case (kind_e'(kind_q))
      KindSample: res_d.shaken = (delta > thresh_q);
      KindPlace: if (range_q) begin
        wr_en          = commit;
        wr_entry.pos_x = {cx, {QBits{1'b0}}};
        wr_entry.pos_y = {cy, {QBits{1'b0}}};
        wr_entry.vel_x = '0;
        wr_entry.vel_y = '0;
        wr_entry.drw_x = cx;
        wr_entry.drw_y = cy;
        res_d.moved    = 1'b1;
        res_d.old_x    = cx;
        res_d.old_y    = cy;
        res_d.new_x    = cx;
        res_d.new_y    = cy;
      end
      KindStep: if (range_q) begin
        wr_en          = commit;
        wr_entry.pos_x = npx;
        wr_entry.pos_y = npy;
        wr_entry.vel_x = nvx;
        wr_entry.vel_y = nvy;
        wr_entry.drw_x = npx[PosW-1:QBits];
        wr_entry.drw_y = npy[PosW-1:QBits];
        res_d.moved    = (npx[PosW-1:QBits] != rd_entry.drw_x)
                      || (npy[PosW-1:QBits] != rd_entry.drw_y);
        res_d.old_x    = rd_entry.drw_x;
        res_d.old_y    = rd_entry.drw_y;
        res_d.new_x    = npx[PosW-1:QBits];
        res_d.new_y    = npy[PosW-1:QBits];
      end
      default: ;  // unused kind: flag only
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (commit) begin
      res_vld_q <= 1'b1;
    end else if (result_o.ready) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid       = res_vld_q;
  assign result_o.shaken      = res_q.shaken;
  assign result_o.moved       = res_q.moved;
  assign result_o.old_x_pixel = res_q.old_x;
  assign result_o.old_y_pixel = res_q.old_y;
  assign result_o.new_x_pixel = res_q.new_x;
  assign result_o.new_y_pixel = res_q.new_y;

endmodule
